// ===== hdl/mr_pkg.sv =====
// package for the miller-rabin primality tester: constants, witness table, control types
`timescale 1ns / 1ps
package mr_pkg;

  localparam int unsigned NumW = 63;
  localparam int unsigned BitW = 6;
  localparam int unsigned NumBrackets = 9;
  localparam int unsigned PoolSize = 49;
  localparam int unsigned PoolW = 6;

  typedef logic [NumW-1:0] num_t;

  // witness pool, grouped by bracket
  function automatic num_t witness(input logic [PoolW-1:0] idx);
    num_t w;
    w = '0;
    unique case (idx)
      6'd0:  w = 63'd2;
      6'd1:  w = 63'd31;
      6'd2:  w = 63'd73;
      6'd3:  w = 63'd2;
      6'd4:  w = 63'd7;
      6'd5:  w = 63'd61;
      6'd6:  w = 63'd2;
      6'd7:  w = 63'd13;
      6'd8:  w = 63'd23;
      6'd9:  w = 63'd1662803;
      6'd10: w = 63'd2;
      6'd11: w = 63'd3;
      6'd12: w = 63'd5;
      6'd13: w = 63'd7;
      6'd14: w = 63'd11;
      6'd15: w = 63'd2;
      6'd16: w = 63'd3;
      6'd17: w = 63'd5;
      6'd18: w = 63'd7;
      6'd19: w = 63'd11;
      6'd20: w = 63'd13;
      6'd21: w = 63'd2;
      6'd22: w = 63'd3;
      6'd23: w = 63'd5;
      6'd24: w = 63'd7;
      6'd25: w = 63'd11;
      6'd26: w = 63'd13;
      6'd27: w = 63'd17;
      6'd28: w = 63'd2;
      6'd29: w = 63'd3;
      6'd30: w = 63'd5;
      6'd31: w = 63'd7;
      6'd32: w = 63'd11;
      6'd33: w = 63'd13;
      6'd34: w = 63'd17;
      6'd35: w = 63'd19;
      6'd36: w = 63'd23;
      6'd37: w = 63'd2;
      6'd38: w = 63'd3;
      6'd39: w = 63'd5;
      6'd40: w = 63'd7;
      6'd41: w = 63'd11;
      6'd42: w = 63'd13;
      6'd43: w = 63'd17;
      6'd44: w = 63'd19;
      6'd45: w = 63'd23;
      6'd46: w = 63'd29;
      6'd47: w = 63'd31;
      6'd48: w = 63'd37;
      default: w = 63'd2;
    endcase
    return w;
  endfunction

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SPLIT,
    ST_WSTART,
    ST_WRED,
    ST_PSQ,
    ST_PMUL,
    ST_PWAIT,
    ST_PEVAL,
    ST_SQ,
    ST_SQWAIT,
    ST_DONE
  } state_t;

  // datapath commands
  typedef struct packed {
    logic load;        // capture number
    logic split_step;  // shift d right by one, count s
    logic wit_load;    // load witness, start a mod n
    logic mul_sq;      // start multiply x*x
    logic mul_base;    // start multiply x*a
    logic x_to_one;    // x = 1
    logic next_wit;    // advance witness index
    logic bit_dec;     // advance exponent bit
    logic sq_inc;      // count squaring
  } dp_cmd_t;

  // datapath status
  typedef struct packed {
    logic trivial;     // answer known without rounds
    logic trivial_val;
    logic d_odd;
    logic mul_busy;
    logic wit_zero;    // witness reduced to zero
    logic x_one;
    logic x_nm1;
    logic e_bit;       // current exponent bit
    logic bit_last;
    logic sq_last;     // no squarings left
    logic wit_last;
  } dp_stat_t;

endpackage

// ===== hdl/mr_datapath.sv =====
// datapath: operand registers, bit-serial modular multiplier and witness reduction
`timescale 1ns / 1ps
module mr_datapath #(
  parameter int unsigned NUM_W = mr_pkg::NumW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [NUM_W-1:0]  number,
  input  mr_pkg::dp_cmd_t   cmd,
  output mr_pkg::dp_stat_t  stat
);

  localparam int unsigned BIT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]        n;
  logic [NUM_W-1:0]        d;
  logic [BIT_W-1:0]        s;
  logic [BIT_W-1:0]        sq_cnt;
  logic [BIT_W-1:0]        ebit;
  logic [NUM_W-1:0]        a;
  logic [NUM_W-1:0]        x;
  logic [3:0]              wcnt;
  logic [mr_pkg::PoolW-1:0] widx;

  // multiplier state
  logic                    mbusy;
  logic [BIT_W-1:0]        mcnt;
  logic [NUM_W-1:0]        macc;
  logic [NUM_W-1:0]        mx;
  logic [NUM_W-1:0]        my;
  logic                    mred;   // reduction mode: a mod n by shifting bits in

  logic [NUM_W:0]          dbl;
  logic [NUM_W-1:0]        dbl_r;
  logic [NUM_W:0]          add;
  logic [NUM_W-1:0]        add_r;
  logic [NUM_W-1:0]        acc_next;
  logic [NUM_W-1:0]        nm1;

  assign nm1 = n - NUM_W'(1);

  // one shift-and-add step of (mx*my) mod n, msb of my first
  always_comb begin
    dbl   = {macc, 1'b0};
    if (mred) dbl[0] = my[NUM_W-1];
    dbl_r = (dbl >= {1'b0, n}) ? NUM_W'(dbl - {1'b0, n}) : dbl[NUM_W-1:0];
    add   = {1'b0, dbl_r} + {1'b0, mx};
    add_r = (add >= {1'b0, n}) ? NUM_W'(add - {1'b0, n}) : add[NUM_W-1:0];
    acc_next = (!mred && my[NUM_W-1]) ? add_r : dbl_r;
  end

  // bracket selection from the input value
  function automatic logic [3:0] bracket(input logic [NUM_W-1:0] v);
    logic [3:0] b;
    b = 4'd8;
    priority if (v < NUM_W'(64'd2047))                b = 4'd0;
    else if (v < NUM_W'(64'd9080191))                 b = 4'd1;
    else if (v < NUM_W'(64'd4759123141))              b = 4'd2;
    else if (v < NUM_W'(64'd1122004669633))           b = 4'd3;
    else if (v < NUM_W'(64'd2152302898747))           b = 4'd4;
    else if (v < NUM_W'(64'd3474749660383))           b = 4'd5;
    else if (v < NUM_W'(64'd341550071728321))         b = 4'd6;
    else if (v < NUM_W'(64'd3825123056546413051))     b = 4'd7;
    else                                              b = 4'd8;
    return b;
  endfunction

  function automatic logic [mr_pkg::PoolW-1:0] first_of(input logic [3:0] b);
    logic [mr_pkg::PoolW-1:0] f;
    unique case (b)
      4'd0: f = 6'd0;
      4'd1: f = 6'd1;
      4'd2: f = 6'd3;
      4'd3: f = 6'd6;
      4'd4: f = 6'd10;
      4'd5: f = 6'd15;
      4'd6: f = 6'd21;
      4'd7: f = 6'd28;
      default: f = 6'd37;
    endcase
    return f;
  endfunction

  function automatic logic [3:0] count_of(input logic [3:0] b);
    logic [3:0] c;
    unique case (b)
      4'd0: c = 4'd1;
      4'd1: c = 4'd2;
      4'd2: c = 4'd3;
      4'd3: c = 4'd4;
      4'd4: c = 4'd5;
      4'd5: c = 4'd6;
      4'd6: c = 4'd7;
      4'd7: c = 4'd9;
      default: c = 4'd12;
    endcase
    return c;
  endfunction

  // operand and loop registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n      <= number;
      d      <= number - NUM_W'(1);
      s      <= '0;
      widx   <= first_of(bracket(number));
      wcnt   <= count_of(bracket(number)) - 4'd1;
    end
    if (cmd.split_step) begin
      d <= d >> 1;
      s <= s + BIT_W'(1);
    end
    if (cmd.next_wit) begin
      widx <= widx + mr_pkg::PoolW'(1);
      wcnt <= wcnt - 4'd1;
    end
    if (cmd.wit_load) begin
      ebit   <= BIT_W'(NUM_W - 1);
      sq_cnt <= BIT_W'(1);
    end
    if (cmd.bit_dec) ebit <= ebit - BIT_W'(1);
    if (cmd.sq_inc) sq_cnt <= sq_cnt + BIT_W'(1);
    if (cmd.x_to_one) x <= NUM_W'(1);
    // multiplier result lands in x, reduced witness in a
    if (mbusy && mcnt == '0) begin
      if (mred) a <= acc_next;
      else      x <= acc_next;
    end
  end

  // multiplier sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
    end else if (cmd.wit_load || cmd.mul_sq || cmd.mul_base) begin
      mbusy <= 1'b1;
    end else if (mbusy && mcnt == '0) begin
      mbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wit_load) begin
      mred <= 1'b1;
      macc <= '0;
      mx   <= '0;
      my   <= mr_pkg::witness(widx);
      mcnt <= BIT_W'(NUM_W - 1);
    end else if (cmd.mul_sq || cmd.mul_base) begin
      mred <= 1'b0;
      macc <= '0;
      mx   <= cmd.mul_base ? a : x;
      my   <= x;
      mcnt <= BIT_W'(NUM_W - 1);
    end else if (mbusy) begin
      macc <= acc_next;
      my   <= my << 1;
      mcnt <= mcnt - BIT_W'(1);
    end
  end

  // status to the controller
  always_comb begin
    stat.trivial     = (number < NUM_W'(3)) || !number[0];
    stat.trivial_val = (number == NUM_W'(2));
    stat.d_odd       = d[0];
    stat.mul_busy    = mbusy;
    stat.wit_zero    = (a == '0);
    stat.x_one       = (x == NUM_W'(1));
    stat.x_nm1       = (x == nm1);
    stat.e_bit       = d[ebit];
    stat.bit_last    = (ebit == '0);
    stat.sq_last     = (sq_cnt >= s);
    stat.wit_last    = (wcnt == 4'd0);
  end

endmodule

// ===== hdl/mr_control.sv =====
// controller: sequences split, witness rounds, power and squarings
`timescale 1ns / 1ps
module mr_control (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mr_pkg::dp_stat_t stat,
  output mr_pkg::dp_cmd_t  cmd,
  output logic             busy,
  output logic             done,
  output logic             is_prime
);

  mr_pkg::state_t state, state_next;
  logic           res, res_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mr_pkg::ST_IDLE;
      res   <= 1'b0;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    res_next   = res;
    cmd        = '0;
    busy       = (state != mr_pkg::ST_IDLE);
    done       = 1'b0;
    is_prime   = res;
    unique case (state)
      mr_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.trivial) begin
            res_next   = stat.trivial_val;
            state_next = mr_pkg::ST_DONE;
          end else begin
            state_next = mr_pkg::ST_SPLIT;
          end
        end
      end
      mr_pkg::ST_CHECK: state_next = mr_pkg::ST_SPLIT;
      mr_pkg::ST_SPLIT: begin
        if (stat.d_odd) begin
          state_next = mr_pkg::ST_WSTART;
        end else begin
          cmd.split_step = 1'b1;
        end
      end
      mr_pkg::ST_WSTART: begin
        cmd.wit_load = 1'b1;
        cmd.x_to_one = 1'b1;
        state_next   = mr_pkg::ST_WRED;
      end
      mr_pkg::ST_WRED: begin
        if (!stat.mul_busy) begin
          if (stat.wit_zero) state_next = mr_pkg::ST_PEVAL;
          else               state_next = mr_pkg::ST_PSQ;
        end
      end
      mr_pkg::ST_PSQ: begin
        cmd.mul_sq = 1'b1;
        state_next = mr_pkg::ST_PMUL;
      end
      mr_pkg::ST_PMUL: begin
        if (!stat.mul_busy) begin
          if (stat.e_bit) begin
            cmd.mul_base = 1'b1;
          end
          state_next = mr_pkg::ST_PWAIT;
        end
      end
      mr_pkg::ST_PWAIT: begin
        if (!stat.mul_busy) begin
          cmd.bit_dec = 1'b1;
          if (stat.bit_last) state_next = mr_pkg::ST_PEVAL;
          else               state_next = mr_pkg::ST_PSQ;
        end
      end
      mr_pkg::ST_PEVAL: begin
        if (stat.wit_zero || stat.x_one || stat.x_nm1) begin
          if (stat.wit_last) begin
            res_next   = 1'b1;
            state_next = mr_pkg::ST_DONE;
          end else begin
            cmd.next_wit = 1'b1;
            state_next   = mr_pkg::ST_WSTART;
          end
        end else if (stat.sq_last) begin
          res_next   = 1'b0;
          state_next = mr_pkg::ST_DONE;
        end else begin
          cmd.mul_sq = 1'b1;
          state_next = mr_pkg::ST_SQWAIT;
        end
      end
      mr_pkg::ST_SQWAIT: begin
        if (!stat.mul_busy) begin
          cmd.sq_inc = 1'b1;
          state_next = mr_pkg::ST_SQ;
        end
      end
      mr_pkg::ST_SQ: begin
        if (stat.x_nm1) begin
          if (stat.wit_last) begin
            res_next   = 1'b1;
            state_next = mr_pkg::ST_DONE;
          end else begin
            cmd.next_wit = 1'b1;
            state_next   = mr_pkg::ST_WSTART;
          end
        end else if (stat.sq_last) begin
          res_next   = 1'b0;
          state_next = mr_pkg::ST_DONE;
        end else begin
          cmd.mul_sq = 1'b1;
          state_next = mr_pkg::ST_SQWAIT;
        end
      end
      mr_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = mr_pkg::ST_IDLE;
      end
      default: state_next = mr_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/miller_rabin_primality_test.sv =====
// top level of the deterministic miller-rabin primality tester
// usage:
//   raise start with number while busy is low; that edge is the input transfer
//   busy stays high until the answer has been shown
//   done pulses for one cycle with is_prime; that cycle is the result transfer
//   the receiver cannot stall; is_prime keeps the result after the done cycle until the next answer or reset
// timing:
//   trivial inputs (below 3 or even) answer in the cycle right after the transfer
//   otherwise each modular multiply runs on the bit-serial unit, one shift-and-add step per bit
//   each witness costs one reduction plus up to 126 multiplies for the power and up to s-1 squarings
//   up to 12 witnesses per item
//   the next number is taken only after done, one item at a time
// reset:
//   rst clears the controller to idle and drops busy and done
`timescale 1ns / 1ps
module miller_rabin_primality_test #(
  parameter int unsigned NUM_W = mr_pkg::NumW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] number,
  output logic             busy,
  output logic             done,
  output logic             is_prime
);

  mr_pkg::dp_cmd_t  cmd;
  mr_pkg::dp_stat_t stat;

  // sequencing
  mr_control u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done),
    .is_prime (is_prime)
  );

  // arithmetic
  mr_datapath #(.NUM_W(NUM_W)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .number (number),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the miller-rabin primality tester
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned NumBounds = 8;
  localparam logic [62:0] BracketBound [NumBounds] = '{
    63'd2047, 63'd9080191, 63'd4759123141, 63'd1122004669633,
    63'd2152302898747, 63'd3474749660383, 63'd341550071728321,
    63'd3825123056546413051
  };
  localparam int unsigned WitCount [mr_pkg::NumBrackets] = '{1, 2, 3, 4, 5, 6, 7, 9, 12};
  localparam logic [31:0] WitList [mr_pkg::NumBrackets][12] = '{
    '{2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{31, 73, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{2, 7, 61, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{2, 13, 23, 1662803, 0, 0, 0, 0, 0, 0, 0, 0},
    '{2, 3, 5, 7, 11, 0, 0, 0, 0, 0, 0, 0},
    '{2, 3, 5, 7, 11, 13, 0, 0, 0, 0, 0, 0},
    '{2, 3, 5, 7, 11, 13, 17, 0, 0, 0, 0, 0},
    '{2, 3, 5, 7, 11, 13, 17, 19, 23, 0, 0, 0},
    '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37}
  };

  logic clk;
  logic rst;
  logic start;
  mr_pkg::num_t number;
  logic busy;
  logic done;
  logic is_prime;

  mr_pkg::num_t pending_numbers[$];
  logic expected_answers[$];
  int   gap_left;
  int   pause_at;
  int   accepted;
  bit   stimulus_done;
  bit   failed;

  miller_rabin_primality_test dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .number(number),
    .busy(busy),
    .done(done),
    .is_prime(is_prime)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // exact product reduced modulo n
  function automatic mr_pkg::num_t mod_product(mr_pkg::num_t x, mr_pkg::num_t y,
                                               mr_pkg::num_t n);
    logic [127:0] p;
    p = {65'd0, x} * {65'd0, y};
    p = p % {65'd0, n};
    return p[62:0];
  endfunction

  function automatic mr_pkg::num_t mod_power(mr_pkg::num_t base, mr_pkg::num_t e,
                                             mr_pkg::num_t n);
    mr_pkg::num_t r;
    r = 63'd1 % n;
    for (int b = 62; b >= 0; b--) begin
      r = mod_product(r, r, n);
      if (e[b]) r = mod_product(r, base, n);
    end
    return r;
  endfunction

  // one strong-probable-prime round for witness a
  function automatic bit passes_round(mr_pkg::num_t a, int s, mr_pkg::num_t d,
                                      mr_pkg::num_t n);
    mr_pkg::num_t x;
    a = a % n;
    if (a == 0) return 1'b1;
    x = mod_power(a, d, n);
    if (x == 1 || x == n - 1) return 1'b1;
    for (int i = 1; i < s; i++) begin
      x = mod_product(x, x, n);
      if (x == n - 1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic primality(mr_pkg::num_t n);
    mr_pkg::num_t d;
    int   s;
    int   br;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (!n[0]) return 1'b0;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    br = mr_pkg::NumBrackets - 1;
    for (int k = NumBounds - 1; k >= 0; k--) begin
      if (n < BracketBound[k]) br = k;
    end
    for (int k = 0; k < WitCount[br]; k++) begin
      if (!passes_round(mr_pkg::num_t'(WitList[br][k]), s, d, n)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic mr_pkg::num_t random_num();
    return mr_pkg::num_t'({$urandom, $urandom});
  endfunction

  // next prime at or above a random odd start point
  function automatic mr_pkg::num_t prime_from(mr_pkg::num_t n);
    n[0] = 1'b1;
    while (!primality(n)) n = n + 2;
    return n;
  endfunction

  // driver: one transfer per accepted number, random gaps between them
  always @(posedge clk) begin
    logic drive;
    logic take;
    drive = start;
    take = 1'b0;
    if (rst) begin
      drive = 1'b0;
    end else begin
      if (start && !busy) begin
        expected_answers.push_back(primality(number));
        accepted++;
        take = 1'b1;
        drive = 1'b0;
        if ($urandom_range(0, 9) < 7) gap_left = $urandom_range(0, 2);
        else gap_left = $urandom_range(10, 60);
        if (accepted > 40 && accepted < 55) gap_left = 0;
      end
      if (!drive && !take) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (accepted == pause_at && expected_answers.size() != 0) begin
          // hold off until the tester has drained
        end else if (pending_numbers.size() != 0) begin
          drive = 1'b1;
          number <= pending_numbers.pop_front();
        end
      end else if (take && gap_left == 0 && accepted != pause_at
                   && pending_numbers.size() != 0) begin
        drive = 1'b1;
        number <= pending_numbers.pop_front();
      end
    end
    start <= drive;
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    logic want;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual is_prime=%0b",
                 $time, is_prime);
        failed = 1'b1;
      end else begin
        want = expected_answers.pop_front();
        if (is_prime !== want) begin
          $display("%0t: is_prime mismatch, expected %0b, actual %0b",
                   $time, want, is_prime);
          failed = 1'b1;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    mr_pkg::num_t v;
    start = 1'b0;
    number = '0;
    gap_left = 0;
    accepted = 0;
    failed = 1'b0;
    stimulus_done = 1'b0;
    pause_at = 20;
    rst = 1'b1;

    // directed: small values, bracket edges, pseudoprimes, extremes
    pending_numbers = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd9, 63'd561,
                        63'd2046, 63'd2047, 63'd2053, 63'd9080191, 63'd9080189,
                        63'd3215031751, 63'd4759123141, 63'd1122004669633,
                        63'd3474749660383, 63'd341550071728321,
                        63'd3825123056546413051, 63'd2305843009213693951,
                        63'd9223372036854775783, 63'h7fffffffffffffff,
                        63'h7ffffffffffffffe, 63'h5555555555555555,
                        63'h2aaaaaaaaaaaaaaa};

    // random: small and wide values, primes, odd values and values near bracket bounds
    for (int i = 0; i < 100; i++) begin
      v = random_num();
      case ($urandom_range(0, 9))
        0, 1: v = v % 63'd1048576;
        2: v = prime_from(v % 63'd1048576);
        3: v = prime_from(v % 63'd4294967296);
        4: v = v % 63'd1099511627776;
        5, 6: v = BracketBound[$urandom_range(0, NumBounds - 1)]
                  + mr_pkg::num_t'($urandom_range(0, 10)) - 63'd5;
        7: v = v | 63'd1;
        8: v = prime_from(v % 63'd281474976710656);
        default: if (i % 20 == 0) v = prime_from(v);
      endcase
      pending_numbers.push_back(v);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    wait (pending_numbers.size() == 0 && !start);
    wait (expected_answers.size() == 0);
    repeat (50) @(posedge clk);
    if (!failed && expected_answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #500000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
